@@ sv/gbl_pkg.sv @@
// Shared types and constants for the glyph bitmap to LCD byte stream block.
// Used by the front end, the job queue, the back end and the top level.
package gbl_pkg;

  // Default limit on the glyph side, in pixels
  localparam int MAX_SIDE_DEF = 32;
  // Compare width for a 6-bit size register against any side limit up to 64
  localparam int CMP_W = 7;
  // Entries in the queue between front and back end
  localparam int JOBQ_DEPTH = 2;
  // Number of results in the window setup sequence
  localparam int START_LEN = 11;

  // Controller command bytes
  localparam logic [7:0] CMD_COL_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FG_COLOR     = 3'd0,
    REG_BG_COLOR     = 3'd1,
    REG_GLYPH_WIDTH  = 3'd2,
    REG_GLYPH_HEIGHT = 3'd3,
    REG_COL_OFFSET   = 3'd4,
    REG_ROW_OFFSET   = 3'd5
  } cfg_reg_e;

  // Input item function codes
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_BYTE  = 1'b1
  } func_e;

  // Kinds of work handed from the front end to the back end
  typedef enum logic {
    JOB_START  = 1'b0,
    JOB_PIXELS = 1'b1
  } job_kind_e;

  typedef struct packed {
    logic       func;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] glyph_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] out_byte;
    logic       last;
    logic       glyph_done;
  } out_item_t;

  typedef struct packed {
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [5:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [7:0]  col_offset;
    logic [7:0]  row_offset;
  } cfg_t;

  // For a start job a..d hold first column, last column, first row and last row.
  // For a pixel job a holds the bitmap byte and npix the pixel count.
  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [3:0] npix;
    logic       done;
  } job_t;

endpackage

@@ sv/gbl_front.sv @@
// Front end: classifies accepted items, tracks glyph row and column and builds jobs.
// Depends on gbl_pkg.
module gbl_front import gbl_pkg::*; #(
  parameter int MAX_GLYPH_SIDE = MAX_SIDE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     acc_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output logic     job_valid_o,
  output job_t     job_o
);

  localparam int SideW = $clog2(MAX_GLYPH_SIDE + 1);

  logic [SideW-1:0] w_eff, h_eff;
  logic [SideW-1:0] row_q, row_d, col_q, col_d;
  logic [SideW-1:0] r1, c1, rem;
  logic             active_q, active_d;
  logic [3:0]       npix;

  // Effective glyph sizes: zero acts as one, large values clamp to the limit.
  always_comb begin
    if (cfg_i.glyph_width == '0) begin
      w_eff = SideW'(1);
    end else if ({1'b0, cfg_i.glyph_width} > CMP_W'(MAX_GLYPH_SIDE)) begin
      w_eff = SideW'(MAX_GLYPH_SIDE);
    end else begin
      w_eff = SideW'(cfg_i.glyph_width);
    end
    if (cfg_i.glyph_height == '0) begin
      h_eff = SideW'(1);
    end else if ({1'b0, cfg_i.glyph_height} > CMP_W'(MAX_GLYPH_SIDE)) begin
      h_eff = SideW'(MAX_GLYPH_SIDE);
    end else begin
      h_eff = SideW'(cfg_i.glyph_height);
    end
  end

  // Classify the item, advance the glyph position and form the job.
  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    active_d    = active_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    r1          = row_q;
    c1          = col_q;
    rem         = '0;
    npix        = '0;
    if (acc_i) begin
      if (item_i.func == FUNC_START) begin
        // A start always opens a fresh glyph, abandoning any old one.
        active_d    = 1'b1;
        row_d       = '0;
        col_d       = '0;
        job_valid_o = 1'b1;
        job_o.kind  = JOB_START;
        job_o.a     = item_i.pos_x + cfg_i.col_offset;
        job_o.b     = item_i.pos_x + 8'(w_eff) - 8'd1 + cfg_i.col_offset;
        job_o.c     = item_i.pos_y + cfg_i.row_offset;
        job_o.d     = item_i.pos_y + 8'(h_eff) - 8'd1 + cfg_i.row_offset;
      end else if (active_q) begin
        if (row_q >= h_eff) begin
          // The height shrank below the current row: the glyph ends here.
          active_d = 1'b0;
          row_d    = '0;
          col_d    = '0;
        end else begin
          // A row already past a shrunk width counts as complete.
          if (col_q >= w_eff) begin
            c1 = '0;
            r1 = row_q + SideW'(1);
          end
          if (r1 >= h_eff) begin
            active_d = 1'b0;
            row_d    = '0;
            col_d    = '0;
          end else begin
            rem         = w_eff - c1;
            npix        = (rem > SideW'(8)) ? 4'd8 : 4'(rem);
            col_d       = c1 + SideW'(npix);
            row_d       = r1;
            job_valid_o = 1'b1;
            job_o.kind  = JOB_PIXELS;
            job_o.a     = item_i.glyph_byte;
            job_o.npix  = npix;
            if (col_d >= w_eff) begin
              col_d = '0;
              row_d = r1 + SideW'(1);
              if (row_d >= h_eff) begin
                job_o.done = 1'b1;
                active_d   = 1'b0;
                row_d      = '0;
              end
            end
          end
        end
      end
    end
  end

  // Glyph position registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      active_q <= 1'b0;
    end else begin
      row_q    <= row_d;
      col_q    <= col_d;
      active_q <= active_d;
    end
  end

  // With no glyph open the position must be back at the origin.
  a_idle_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (row_q == '0) && (col_q == '0))
    else $error("glyph position not cleared while no glyph is open");

  // A pixel job always carries between one and eight pixels.
  a_npix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && (job_o.kind == JOB_PIXELS) |-> (job_o.npix != 4'd0) && (job_o.npix <= 4'd8))
    else $error("pixel job with an impossible pixel count");

endmodule

@@ sv/gbl_jobq.sv @@
// Short job queue between the front end and the back end.
// Depends on gbl_pkg.
module gbl_jobq import gbl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_data_i,
  input  logic rd_i,
  output logic rd_valid_o,
  output job_t rd_data_o,
  output logic full_o
);

  localparam int PtrW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int CntW = $clog2(JOBQ_DEPTH + 1);

  job_t            mem_q [JOBQ_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_rd;

  assign rd_valid_o = (count_q != '0);
  assign full_o     = (count_q == CntW'(JOBQ_DEPTH));
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_rd      = rd_i && rd_valid_o;

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr_i && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (!wr_i && do_rd) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // The front end only writes when a transfer was allowed in.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("job queue written while full");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(JOBQ_DEPTH))
    else $error("job queue fill count out of range");

endmodule

@@ sv/gbl_back.sv @@
// Back end: expands jobs into command, window and RGB565 pixel bytes, one per cycle
// while a job waits and the output is free or popped. Depends on gbl_pkg.
module gbl_back import gbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  input  logic [15:0] fg_color_i,
  input  logic [15:0] bg_color_i,
  output logic        job_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output out_item_t   out_o
);

  logic [3:0] step_q, step_d;
  out_item_t  out_q, res;
  logic       out_valid_q;
  logic       advance, last_step;
  logic [15:0] px;

  // Final step of the current job.
  always_comb begin
    if (job_i.kind == JOB_START) begin
      last_step = (step_q == 4'(START_LEN - 1));
    end else begin
      last_step = ({1'b0, step_q} == ({job_i.npix, 1'b0} - 5'd1));
    end
  end

  // Result byte for the current step.
  always_comb begin
    res        = '0;
    px         = job_i.a[3'd7 - step_q[3:1]] ? fg_color_i : bg_color_i;
    res.last   = last_step;
    if (job_i.kind == JOB_START) begin
      res.is_data = 1'b1;
      case (step_q)
        4'd0: begin
          res.is_data  = 1'b0;
          res.out_byte = CMD_COL_SET;
        end
        4'd2: res.out_byte = job_i.a;
        4'd4: res.out_byte = job_i.b;
        4'd5: begin
          res.is_data  = 1'b0;
          res.out_byte = CMD_ROW_SET;
        end
        4'd7: res.out_byte = job_i.c;
        4'd9: res.out_byte = job_i.d;
        4'd10: begin
          res.is_data  = 1'b0;
          res.out_byte = CMD_MEM_WRITE;
        end
        default: res.out_byte = 8'h00;
      endcase
    end else begin
      // Each pixel goes out high byte first.
      res.is_data    = 1'b1;
      res.out_byte   = step_q[0] ? px[7:0] : px[15:8];
      res.glyph_done = last_step && job_i.done;
    end
  end

  // The output register takes a new result when it is free or being emptied.
  assign advance   = job_valid_i && (!out_valid_q || pop_i);
  assign job_pop_o = advance && last_step;
  assign step_d    = advance ? (last_step ? 4'd0 : step_q + 4'd1) : step_q;
  assign empty_o   = !out_valid_q;
  assign out_o     = out_q;

  // Step counter and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.glyph_done |-> out_q.last)
    else $error("glyph end flagged on a result that is not the last of its item");

  a_start_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && (job_i.kind == JOB_START) |-> step_q < 4'(START_LEN))
    else $error("window setup step out of range");

  a_pixel_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && (job_i.kind == JOB_PIXELS) |-> {1'b0, step_q} < {job_i.npix, 1'b0})
    else $error("pixel step out of range");

endmodule

@@ sv/glyph_bitmap_to_lcd_stream.sv @@
// Glyph bitmap to LCD byte stream: a start item yields the eleven-byte window setup
// (column set, row set, memory write) and each bitmap byte yields two bytes per
// covered pixel, up to sixteen. The output side delivers one byte per clock cycle
// while the output is free or popped; bytes with no glyph open give no output.
// Input is accepted in every cycle while the two-entry job queue between the
// front end and the byte expander has room, so the sustained input rate is set
// by the expander's one byte per cycle.
// Depends on gbl_pkg, gbl_front, gbl_jobq and gbl_back.
module glyph_bitmap_to_lcd_stream import gbl_pkg::*; #(
  parameter int MAX_GLYPH_SIDE = MAX_SIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q;
  logic acc;
  logic job_valid, jq_valid, jq_pop;
  job_t job, jq_head;

  assign cfg_ready_o = 1'b1;
  assign acc         = push && !full;

  // Configuration registers; a write beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg_color     <= 16'hFFFF;
      cfg_q.bg_color     <= 16'h0000;
      cfg_q.glyph_width  <= 6'd16;
      cfg_q.glyph_height <= 6'd16;
      cfg_q.col_offset   <= 8'd0;
      cfg_q.row_offset   <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FG_COLOR:     cfg_q.fg_color     <= cfg_data_i;
        REG_BG_COLOR:     cfg_q.bg_color     <= cfg_data_i;
        REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= cfg_data_i[5:0];
        REG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_data_i[5:0];
        REG_COL_OFFSET:   cfg_q.col_offset   <= cfg_data_i[7:0];
        REG_ROW_OFFSET:   cfg_q.row_offset   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Front end: classification and glyph position tracking.
  gbl_front #(
    .MAX_GLYPH_SIDE(MAX_GLYPH_SIDE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .item_i     (in_item_i),
    .cfg_i      (cfg_q),
    .job_valid_o(job_valid),
    .job_o      (job)
  );

  // Job queue decoupling the two halves.
  gbl_jobq u_jobq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_valid),
    .wr_data_i (job),
    .rd_i      (jq_pop),
    .rd_valid_o(jq_valid),
    .rd_data_o (jq_head),
    .full_o    (full)
  );

  // Back end: byte expansion into the output register.
  gbl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(jq_valid),
    .job_i      (jq_head),
    .fg_color_i (cfg_q.fg_color),
    .bg_color_i (cfg_q.bg_color),
    .job_pop_o  (jq_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_o      (out_item_o)
  );

endmodule
